[src/nmps_pkg.sv]
// ----------------------------------------------------------------------------
// nmps_pkg
// Shared types, sizes and codes for the nearest H-C pair search unit.
// ----------------------------------------------------------------------------
package nmps_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_DIM    = 64;

    localparam int PTR_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int COORD_W = 6;
    localparam int DIST_W  = 7;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CODE_W  = 8;
    localparam int OUT_W   = 40;

    localparam logic [CODE_W-1:0] CODE_H = 8'h48;
    localparam logic [CODE_W-1:0] CODE_C = 8'h43;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_point;

    localparam int POINT_W = $bits(t_point);

    // Packed from found (lowest bit) up to overflow
    typedef struct packed {
        logic               overflow;
        logic [DIST_W-1:0]  distance;
        logic [COORD_W-1:0] c_col;
        logic [COORD_W-1:0] c_row;
        logic [COORD_W-1:0] h_col;
        logic [COORD_W-1:0] h_row;
        logic               found;
    } t_result;

    localparam int RES_W = $bits(t_result);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_FLUSH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;    // record the accepted cell and advance the scan
        logic start;   // reset pair indexes and running minimum
        logic step;    // read one H-C pair and advance the indexes
        logic finish;  // latch result and clear the grid state
    } t_dp_cmd;

    typedef struct packed {
        logic no_pairs;
        logic last_pair;
        logic out_free;
    } t_dp_sts;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > CFG_W'(MAX_DIM)) begin
            r = CFG_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[src/nmps_ram.sv]
// ----------------------------------------------------------------------------
// nmps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nmps_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/nmps_ctrl.sv]
// ----------------------------------------------------------------------------
// nmps_ctrl
// Controller: cell loading, pair search sequencing and result hand-off.
// ----------------------------------------------------------------------------
module nmps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  nmps_pkg::t_dp_sts i_sts,
    output nmps_pkg::t_dp_cmd o_cmd
);

    nmps_pkg::t_state r_state;
    nmps_pkg::t_state n_state;
    logic             in_acc;

    assign in_acc = i_in_valid && (r_state == nmps_pkg::ST_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nmps_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nmps_pkg::ST_LOAD: begin
                if (in_acc && i_in_last) begin
                    n_state = nmps_pkg::ST_SEARCH;
                end
            end
            nmps_pkg::ST_SEARCH: begin
                if (i_sts.no_pairs) begin
                    n_state = nmps_pkg::ST_FINISH;
                end else if (i_sts.last_pair) begin
                    n_state = nmps_pkg::ST_FLUSH;
                end
            end
            nmps_pkg::ST_FLUSH: begin
                n_state = nmps_pkg::ST_FINISH;
            end
            nmps_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = nmps_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = nmps_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            nmps_pkg::ST_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.load   = in_acc;
                o_cmd.start  = in_acc && i_in_last;
            end
            nmps_pkg::ST_SEARCH: begin
                o_cmd.step = !i_sts.no_pairs;
            end
            nmps_pkg::ST_FLUSH: begin
                o_cmd = '0;
            end
            nmps_pkg::ST_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[src/nmps_dp.sv]
// ----------------------------------------------------------------------------
// nmps_dp
// Datapath: grid size registers, scan position, point stores, pair
// distance compare with running minimum, and the output register.
// ----------------------------------------------------------------------------
module nmps_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [nmps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nmps_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [nmps_pkg::CODE_W-1:0]      i_cell_code,
    input  nmps_pkg::t_dp_cmd                i_cmd,
    output nmps_pkg::t_dp_sts                o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output nmps_pkg::t_result                o_result
);

    logic [nmps_pkg::CFG_W-1:0]   r_rows;
    logic [nmps_pkg::CFG_W-1:0]   r_cols;
    logic [nmps_pkg::COORD_W-1:0] r_scan_row;
    logic [nmps_pkg::COORD_W-1:0] r_scan_col;
    logic [nmps_pkg::CNT_W-1:0]   r_h_cnt;
    logic [nmps_pkg::CNT_W-1:0]   r_c_cnt;
    logic                         r_drop;
    logic [nmps_pkg::PTR_W-1:0]   r_hi;
    logic [nmps_pkg::PTR_W-1:0]   r_cj;
    logic                         r_rd_vld;
    logic                         r_found;
    logic [nmps_pkg::DIST_W-1:0]  r_best_d;
    nmps_pkg::t_point             r_best_h;
    nmps_pkg::t_point             r_best_c;
    logic                         r_out_vld;
    nmps_pkg::t_result            r_out;

    logic [nmps_pkg::CFG_W-1:0]   rows_eff;
    logic [nmps_pkg::CFG_W-1:0]   cols_eff;
    logic                         col_wrap;
    logic                         row_wrap;
    logic                         is_h;
    logic                         is_c;
    logic                         h_full;
    logic                         c_full;
    logic                         h_we;
    logic                         c_we;
    nmps_pkg::t_point             cur_pos;
    logic [nmps_pkg::POINT_W-1:0] h_rdata;
    logic [nmps_pkg::POINT_W-1:0] c_rdata;
    nmps_pkg::t_point             h_pt;
    nmps_pkg::t_point             c_pt;
    logic [nmps_pkg::COORD_W-1:0] d_row;
    logic [nmps_pkg::COORD_W-1:0] d_col;
    logic [nmps_pkg::DIST_W-1:0]  pair_dist;
    logic                         better;
    logic                         j_end;
    nmps_pkg::t_result            res_next;

    assign rows_eff = nmps_pkg::clamp_dim(r_rows);
    assign cols_eff = nmps_pkg::clamp_dim(r_cols);
    assign col_wrap = (nmps_pkg::CFG_W'(r_scan_col) + nmps_pkg::CFG_W'(1)) >= cols_eff;
    assign row_wrap = (nmps_pkg::CFG_W'(r_scan_row) + nmps_pkg::CFG_W'(1)) >= rows_eff;

    assign is_h   = (i_cell_code == nmps_pkg::CODE_H);
    assign is_c   = (i_cell_code == nmps_pkg::CODE_C);
    assign h_full = (r_h_cnt == nmps_pkg::CNT_W'(nmps_pkg::MAX_POINTS));
    assign c_full = (r_c_cnt == nmps_pkg::CNT_W'(nmps_pkg::MAX_POINTS));
    assign h_we   = i_cmd.load && is_h && !h_full;
    assign c_we   = i_cmd.load && is_c && !c_full;

    assign cur_pos.row = r_scan_row;
    assign cur_pos.col = r_scan_col;

    nmps_ram #(
        .WIDTH (nmps_pkg::POINT_W),
        .DEPTH (nmps_pkg::MAX_POINTS)
    ) u_h_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (r_h_cnt[nmps_pkg::PTR_W-1:0]),
        .i_wdata (cur_pos),
        .i_raddr (r_hi),
        .o_rdata (h_rdata)
    );

    nmps_ram #(
        .WIDTH (nmps_pkg::POINT_W),
        .DEPTH (nmps_pkg::MAX_POINTS)
    ) u_c_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_c_cnt[nmps_pkg::PTR_W-1:0]),
        .i_wdata (cur_pos),
        .i_raddr (r_cj),
        .o_rdata (c_rdata)
    );

    assign h_pt  = nmps_pkg::t_point'(h_rdata);
    assign c_pt  = nmps_pkg::t_point'(c_rdata);
    assign d_row = (h_pt.row >= c_pt.row) ? (h_pt.row - c_pt.row) : (c_pt.row - h_pt.row);
    assign d_col = (h_pt.col >= c_pt.col) ? (h_pt.col - c_pt.col) : (c_pt.col - h_pt.col);
    assign pair_dist = nmps_pkg::DIST_W'(d_row) + nmps_pkg::DIST_W'(d_col);
    // strictly smaller keeps the earliest pair in stored order on ties
    assign better = !r_found || (pair_dist < r_best_d);

    assign j_end = (nmps_pkg::CNT_W'(r_cj) + nmps_pkg::CNT_W'(1)) == r_c_cnt;

    assign o_sts.no_pairs  = (r_h_cnt == '0) || (r_c_cnt == '0);
    assign o_sts.last_pair = j_end &&
        ((nmps_pkg::CNT_W'(r_hi) + nmps_pkg::CNT_W'(1)) == r_h_cnt);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    always_comb begin
        res_next          = '0;
        res_next.overflow = r_drop;
        if (r_found) begin
            res_next.found    = 1'b1;
            res_next.h_row    = r_best_h.row;
            res_next.h_col    = r_best_h.col;
            res_next.c_row    = r_best_c.row;
            res_next.c_col    = r_best_c.col;
            res_next.distance = r_best_d;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= nmps_pkg::DIM_RESET;
            r_cols     <= nmps_pkg::DIM_RESET;
            r_scan_row <= '0;
            r_scan_col <= '0;
            r_h_cnt    <= '0;
            r_c_cnt    <= '0;
            r_drop     <= 1'b0;
            r_hi       <= '0;
            r_cj       <= '0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    nmps_pkg::CFG_GRID_ROWS: r_rows <= i_cfg_data;
                    nmps_pkg::CFG_GRID_COLS: r_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.load) begin
                if (h_we) begin
                    r_h_cnt <= r_h_cnt + nmps_pkg::CNT_W'(1);
                end
                if (c_we) begin
                    r_c_cnt <= r_c_cnt + nmps_pkg::CNT_W'(1);
                end
                if ((is_h && h_full) || (is_c && c_full)) begin
                    r_drop <= 1'b1;
                end
                if (col_wrap) begin
                    r_scan_col <= '0;
                    r_scan_row <= row_wrap ? '0 : r_scan_row + nmps_pkg::COORD_W'(1);
                end else begin
                    r_scan_col <= r_scan_col + nmps_pkg::COORD_W'(1);
                end
            end

            if (i_cmd.start) begin
                r_hi    <= '0;
                r_cj    <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.step) begin
                if (j_end) begin
                    r_cj <= '0;
                    r_hi <= r_hi + nmps_pkg::PTR_W'(1);
                end else begin
                    r_cj <= r_cj + nmps_pkg::PTR_W'(1);
                end
            end

            r_rd_vld <= i_cmd.step;
            if (r_rd_vld && better) begin
                r_found <= 1'b1;
            end

            if (i_cmd.finish) begin
                r_out_vld  <= 1'b1;
                r_h_cnt    <= '0;
                r_c_cnt    <= '0;
                r_scan_row <= '0;
                r_scan_col <= '0;
                r_drop     <= 1'b0;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && better) begin
            r_best_d <= pair_dist;
            r_best_h <= h_pt;
            r_best_c <= c_pt;
        end
        if (i_cmd.finish) begin
            r_out <= res_next;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule

[src/nearest_manhattan_pair_search_unit.sv]
// ----------------------------------------------------------------------------
// nearest_manhattan_pair_search_unit
// Records H and C cell positions of a streamed grid and returns the H-C
// pair with the smallest Manhattan distance after the last cell.
// ----------------------------------------------------------------------------
// Cells are taken one per cycle while loading. After the last cell the input is
// held off for the search: one pair per cycle through the registered reads of
// the two point RAMs, a compare flush and a result latch, or the latch alone
// when either list is empty. The result is valid as the input reopens; a result
// still waiting in the output register delays the latch. Synchronous active-low reset clears
// control state; point RAMs are not cleared, only entries below the counts are read.
module nearest_manhattan_pair_search_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [nmps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nmps_pkg::CFG_W-1:0]         i_cfg_data,
    // cell stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [nmps_pkg::CODE_W-1:0]        s_axis_tdata,  // [7:0] cell_code
    input  logic                               s_axis_tlast,  // last_cell
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // from bit 0: found, h_row, h_col, c_row, c_col, distance, overflow, zero pad
    output logic [nmps_pkg::OUT_W-1:0]         m_axis_tdata
);

    nmps_pkg::t_dp_cmd cmd;
    nmps_pkg::t_dp_sts sts;
    nmps_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    nmps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nmps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cell_code (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (result)
    );

    assign m_axis_tdata = {{(nmps_pkg::OUT_W - nmps_pkg::RES_W){1'b0}}, result};

endmodule
